// File: rtl/core/rst_pkg.sv
// Package for the request slot tracker: slot count, status and opcode codes,
// and the structs shared by the slot store and the top level.
// No dependencies.
`default_nettype none

package rst_pkg;

  localparam int unsigned SLOTS  = 8;
  localparam int unsigned SLOT_W = $clog2(SLOTS);

  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [SLOT_W:0]   slot_cnt_t;

  localparam slot_cnt_t SLOT_CNT = slot_cnt_t'(SLOTS);

  localparam logic [2:0] OP_ALLOC  = 3'd0;
  localparam logic [2:0] OP_OLDEST = 3'd1;
  localparam logic [2:0] OP_WAIT   = 3'd2;
  localparam logic [2:0] OP_NET    = 3'd3;
  localparam logic [2:0] OP_SET    = 3'd4;
  localparam logic [2:0] OP_SWEEP  = 3'd5;

  localparam logic [2:0] ST_EMPTY          = 3'd0;
  localparam logic [2:0] ST_SERIAL_READY   = 3'd1;
  localparam logic [2:0] ST_SERIAL_NOREPLY = 3'd2;
  localparam logic [2:0] ST_SERIAL_WAIT    = 3'd3;
  localparam logic [2:0] ST_NET_READY      = 3'd4;

  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  typedef struct packed {
    logic [31:0] stamp;
    logic [1:0]  owner;
    logic [8:0]  len;
  } slot_pl_t;

  localparam int unsigned PL_W = $bits(slot_pl_t);

  typedef struct packed {
    logic      rd_en;
    slot_idx_t rd_addr;
    logic      st_we;
    logic      pl_we;
    slot_idx_t wr_addr;
    logic [2:0] wr_state;
    slot_pl_t  wr_pl;
    logic      clr_en;
    slot_idx_t clr_addr;
  } store_cmd_t;

  typedef struct packed {
    logic [2:0] state;
    slot_pl_t   pl;
  } store_rd_t;

  typedef struct packed {
    logic       found;
    logic [2:0] found_slot;
    logic [1:0] found_client;
    logic [8:0] found_length;
    logic [2:0] found_status;
    logic [3:0] freed_count;
  } rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/rst_if.sv
// Channel interfaces of the request slot tracker: request, response and
// configuration words, each with valid/ready. No dependencies.
`default_nettype none

interface rst_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [31:0] now_ms;
  logic [2:0] slot_index;
  logic [2:0] new_status;
  logic [1:0] client_id;
  logic [7:0] unit_id;
  logic [8:0] frame_length;

  modport source (output valid, opcode, now_ms, slot_index, new_status, client_id,
                  unit_id, frame_length, input ready);
  modport sink   (input valid, opcode, now_ms, slot_index, new_status, client_id,
                  unit_id, frame_length, output ready);
endinterface

interface rst_rsp_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [2:0] found_slot;
  logic [1:0] found_client;
  logic [8:0] found_length;
  logic [2:0] found_status;
  logic [3:0] freed_count;

  modport source (output valid, found, found_slot, found_client, found_length,
                  found_status, freed_count, input ready);
  modport sink   (input valid, found, found_slot, found_client, found_length,
                  found_status, freed_count, output ready);
endinterface

interface rst_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/rst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rst_slot_store.sv
// Slot store: status RAM with per-slot valid flags, and payload RAM
// (stamp, owner, length). Depends on rst_pkg and rst_ram.
`default_nettype none

module rst_slot_store
  import rst_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire store_cmd_t cmd_i,
  output store_rd_t       rd_o
);

  logic [SLOTS-1:0] valid_q;
  logic             rd_valid_q;
  logic [2:0]       st_rdata;
  logic [PL_W-1:0]  pl_rdata;

  rst_ram #(.WIDTH(3), .DEPTH(SLOTS)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.st_we),
    .waddr_i (cmd_i.wr_addr),
    .wdata_i (cmd_i.wr_state),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (st_rdata)
  );

  rst_ram #(.WIDTH(PL_W), .DEPTH(SLOTS)) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.pl_we),
    .waddr_i (cmd_i.wr_addr),
    .wdata_i (cmd_i.wr_pl),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (pl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd_i.st_we) begin
        valid_q[cmd_i.wr_addr] <= 1'b1;
      end
      if (cmd_i.clr_en) begin
        valid_q[cmd_i.clr_addr] <= 1'b0;
      end
      if (cmd_i.rd_en) begin
        rd_valid_q <= valid_q[cmd_i.rd_addr];
      end
    end
  end

  assign rd_o.state = rd_valid_q ? st_rdata : ST_EMPTY;
  assign rd_o.pl    = slot_pl_t'(pl_rdata);

endmodule

`default_nettype wire

// File: rtl/core/request_slot_tracker.sv
// Request slot tracker top level: command sequencer around the slot store.
// Depends on rst_pkg, rst_if and rst_slot_store.
//
// Usage:
//   req_i carries one command word (opcode, time, slot, status, client, unit,
//   length); rsp_o returns exactly one result word per command. cfg_i writes
//   the timeout limit and is always ready; write it only while idle.
//   Search, allocate and sweep commands walk every slot through the store
//   RAMs, one read per cycle, before the result is offered; set and unknown
//   opcodes skip the scan and pass straight to the completion state.
//   One command is in work at a time, so req_i is ready only when the
//   sequencer is idle; the result sits in an output register, so the next
//   command is taken while the previous result still waits on rsp_o.
//   If rsp_o stalls with a result already held, the next command finishes
//   and waits until that word is taken.
//   Reset marks every slot empty, the allocation pointer at slot 0 and the
//   timeout at 1000 ms; it needs no clearing pass.
`default_nettype none

module request_slot_tracker
  import rst_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rst_req_if.sink   req_i,
  rst_rsp_if.source rsp_o,
  rst_cfg_if.sink   cfg_i
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } seq_state_e;

  seq_state_e  state_q, state_d;
  logic        rsp_vld_q, rsp_vld_d;
  rsp_t        rsp_q, rsp_d;
  slot_idx_t   ptr_q, ptr_d;
  logic [31:0] limit_q, limit_d;
  slot_cnt_t   iss_q, iss_d;
  logic        rd_vld_q, rd_vld_d;
  slot_idx_t   rd_idx_q, rd_idx_d;
  logic        have_q, have_d;
  logic [3:0]  freed_q, freed_d;

  logic [2:0]  op_q, op_d;
  logic [31:0] now_q, now_d;
  logic [1:0]  cli_q, cli_d;
  logic [7:0]  unit_q, unit_d;
  logic [8:0]  len_q, len_d;
  slot_idx_t   best_idx_q, best_idx_d;
  logic [1:0]  best_cli_q, best_cli_d;
  logic [8:0]  best_len_q, best_len_d;
  logic [2:0]  best_st_q, best_st_d;
  logic [31:0] best_age_q, best_age_d;

  store_cmd_t  cmd;
  store_rd_t   rd;
  logic        req_acc;
  logic        issue;
  slot_cnt_t   addr_sum;
  slot_idx_t   scan_addr;
  logic [31:0] age;
  logic [2:0]  alloc_st;

  rst_slot_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rd_o   (rd)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign req_acc     = req_i.valid && req_i.ready;

  assign issue = (state_q == S_SCAN) && (iss_q < SLOT_CNT);

  always_comb begin
    addr_sum = iss_q + ((op_q == OP_ALLOC) ? slot_cnt_t'(ptr_q) : '0);
    if (addr_sum >= SLOT_CNT) begin
      addr_sum = addr_sum - SLOT_CNT;
    end
    scan_addr = addr_sum[SLOT_W-1:0];
  end

  assign age      = now_q - rd.pl.stamp;
  assign alloc_st = (unit_q == 8'd0) ? ST_SERIAL_NOREPLY : ST_SERIAL_READY;

  always_comb begin
    state_d    = state_q;
    rsp_vld_d  = rsp_vld_q;
    rsp_d      = rsp_q;
    ptr_d      = ptr_q;
    limit_d    = limit_q;
    iss_d      = iss_q;
    rd_vld_d   = issue;
    rd_idx_d   = scan_addr;
    have_d     = have_q;
    freed_d    = freed_q;
    op_d       = op_q;
    now_d      = now_q;
    cli_d      = cli_q;
    unit_d     = unit_q;
    len_d      = len_q;
    best_idx_d = best_idx_q;
    best_cli_d = best_cli_q;
    best_len_d = best_len_q;
    best_st_d  = best_st_q;
    best_age_d = best_age_q;
    cmd        = '0;

    if (rsp_vld_q && rsp_o.ready) begin
      rsp_vld_d = 1'b0;
    end
    if (cfg_i.valid && cfg_i.ready) begin
      limit_d = cfg_i.data;
    end

    case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          op_d       = req_i.opcode;
          now_d      = req_i.now_ms;
          cli_d      = req_i.client_id;
          unit_d     = req_i.unit_id;
          len_d      = req_i.frame_length;
          have_d     = 1'b0;
          freed_d    = '0;
          iss_d      = '0;
          best_age_d = '0;
          if (req_i.opcode == OP_ALLOC || req_i.opcode == OP_OLDEST ||
              req_i.opcode == OP_WAIT || req_i.opcode == OP_NET ||
              req_i.opcode == OP_SWEEP) begin
            state_d = S_SCAN;
          end else begin
            if (req_i.opcode == OP_SET && 32'(req_i.slot_index) < SLOTS &&
                req_i.new_status <= ST_NET_READY) begin
              cmd.st_we    = 1'b1;
              cmd.wr_addr  = slot_idx_t'(req_i.slot_index);
              cmd.wr_state = req_i.new_status;
            end
            state_d = S_DONE;
          end
        end
      end

      S_SCAN: begin
        if (issue) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = scan_addr;
          iss_d       = iss_q + slot_cnt_t'(1);
        end
        if (rd_vld_q) begin
          case (op_q)
            OP_ALLOC: begin
              if (!have_q && rd.state == ST_EMPTY) begin
                have_d       = 1'b1;
                best_idx_d   = rd_idx_q;
                best_cli_d   = cli_q;
                best_len_d   = len_q;
                best_st_d    = alloc_st;
                cmd.st_we    = 1'b1;
                cmd.pl_we    = 1'b1;
                cmd.wr_addr  = rd_idx_q;
                cmd.wr_state = alloc_st;
                cmd.wr_pl    = '{stamp: now_q, owner: cli_q, len: len_q};
              end
            end
            OP_OLDEST: begin
              if ((rd.state == ST_SERIAL_READY || rd.state == ST_SERIAL_NOREPLY) &&
                  (!have_q || age > best_age_q)) begin
                have_d     = 1'b1;
                best_idx_d = rd_idx_q;
                best_cli_d = rd.pl.owner;
                best_len_d = rd.pl.len;
                best_st_d  = rd.state;
                best_age_d = age;
              end
            end
            OP_WAIT, OP_NET: begin
              if (!have_q && rd.state == ((op_q == OP_WAIT) ? ST_SERIAL_WAIT
                                                            : ST_NET_READY)) begin
                have_d     = 1'b1;
                best_idx_d = rd_idx_q;
                best_cli_d = rd.pl.owner;
                best_len_d = rd.pl.len;
                best_st_d  = rd.state;
              end
            end
            OP_SWEEP: begin
              if (rd.state != ST_EMPTY && age > limit_q) begin
                cmd.clr_en   = 1'b1;
                cmd.clr_addr = rd_idx_q;
                freed_d      = freed_q + 4'd1;
              end
            end
            default: begin
            end
          endcase
          if (!issue) begin
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!rsp_vld_q || rsp_o.ready) begin
          rsp_d.found        = have_q;
          rsp_d.found_slot   = have_q ? 3'(best_idx_q) : 3'd0;
          rsp_d.found_client = have_q ? best_cli_q : 2'd0;
          rsp_d.found_length = have_q ? best_len_q : 9'd0;
          rsp_d.found_status = have_q ? best_st_q : 3'd0;
          rsp_d.freed_count  = freed_q;
          rsp_vld_d          = 1'b1;
          if (op_q == OP_ALLOC && have_q) begin
            ptr_d = best_idx_q;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rsp_vld_q <= 1'b0;
      ptr_q     <= '0;
      limit_q   <= TIMEOUT_RESET;
      iss_q     <= '0;
      rd_vld_q  <= 1'b0;
      have_q    <= 1'b0;
      freed_q   <= '0;
    end else begin
      state_q   <= state_d;
      rsp_vld_q <= rsp_vld_d;
      ptr_q     <= ptr_d;
      limit_q   <= limit_d;
      iss_q     <= iss_d;
      rd_vld_q  <= rd_vld_d;
      have_q    <= have_d;
      freed_q   <= freed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q      <= rsp_d;
    rd_idx_q   <= rd_idx_d;
    op_q       <= op_d;
    now_q      <= now_d;
    cli_q      <= cli_d;
    unit_q     <= unit_d;
    len_q      <= len_d;
    best_idx_q <= best_idx_d;
    best_cli_q <= best_cli_d;
    best_len_q <= best_len_d;
    best_st_q  <= best_st_d;
    best_age_q <= best_age_d;
  end

  assign rsp_o.valid        = rsp_vld_q;
  assign rsp_o.found        = rsp_q.found;
  assign rsp_o.found_slot   = rsp_q.found_slot;
  assign rsp_o.found_client = rsp_q.found_client;
  assign rsp_o.found_length = rsp_q.found_length;
  assign rsp_o.found_status = rsp_q.found_status;
  assign rsp_o.freed_count  = rsp_q.freed_count;

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> iss_q <= SLOT_CNT)
    else $error("scan issued past the last slot");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> state_q == S_SCAN)
    else $error("read data returned outside a scan");

  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_vld_q) |-> $past(state_q == S_DONE))
    else $error("result word loaded outside the completion state");

  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pl_we |-> state_q == S_SCAN && op_q == OP_ALLOC && !have_q)
    else $error("payload written outside the first free slot of an allocation");

endmodule

`default_nettype wire
